// File: hdl/owslv_pkg.sv
// ----------------------------------------------------------------------------
// owslv_pkg
// Shared types and constants for the 1-Wire slave ROM responder.
// ----------------------------------------------------------------------------
package owslv_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ROM_ID       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_MIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ONE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD         = 3'd4;

    localparam logic [63:0] ROM_ID_RST    = 64'hC400_0009_7D79_0401;
    localparam logic [15:0] RESET_MIN_RST = 16'd256;
    localparam logic [7:0]  WRITE_ONE_RST = 8'd15;
    localparam logic [7:0]  PRESENCE_RST  = 8'd120;
    localparam logic [7:0]  HOLD_RST      = 8'd15;

    localparam logic [7:0] CMD_NONE       = 8'h00;
    localparam logic [7:0] CMD_READ_ROM   = 8'h33;
    localparam logic [7:0] CMD_SEARCH_ROM = 8'hF0;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_PRESENCE = 2'd1;
    localparam logic [1:0] ACT_HOLD     = 2'd2;

    localparam logic [1:0] MODE_COMMAND = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_SEARCH  = 2'd2;
    localparam logic [1:0] MODE_OTHER   = 2'd3;

    localparam logic [3:0] ROM_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] rom_id;
        logic [15:0] reset_min_us;
        logic [7:0]  write_one_max_us;
        logic [7:0]  presence_us;
        logic [7:0]  hold_us;
    } cfg_t;

    typedef struct packed {
        logic        line_rising;
        logic [15:0] low_time_us;
    } edge_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] pulse_us;
        logic [1:0] mode;
        logic       command_done;
        logic [7:0] command_byte;
    } result_t;

endpackage

// File: hdl/owslv_cfg.sv
// ----------------------------------------------------------------------------
// owslv_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owslv_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [owslv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owslv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output owslv_pkg::cfg_t                     cfg
);

    owslv_pkg::cfg_t cfg_reg;
    owslv_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                owslv_pkg::REG_ROM_ID:    cfg_next.rom_id           = cfg_data;
                owslv_pkg::REG_RESET_MIN: cfg_next.reset_min_us     = cfg_data[15:0];
                owslv_pkg::REG_WRITE_ONE: cfg_next.write_one_max_us = cfg_data[7:0];
                owslv_pkg::REG_PRESENCE:  cfg_next.presence_us      = cfg_data[7:0];
                owslv_pkg::REG_HOLD:      cfg_next.hold_us          = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rom_id           <= owslv_pkg::ROM_ID_RST;
            cfg_reg.reset_min_us     <= owslv_pkg::RESET_MIN_RST;
            cfg_reg.write_one_max_us <= owslv_pkg::WRITE_ONE_RST;
            cfg_reg.presence_us      <= owslv_pkg::PRESENCE_RST;
            cfg_reg.hold_us          <= owslv_pkg::HOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/owslv_engine.sv
// ----------------------------------------------------------------------------
// owslv_engine
// Protocol state and the per-edge update. One edge is consumed per cycle
// when step is high; the result is combinational and is registered by the
// caller in the same cycle.
// ----------------------------------------------------------------------------
module owslv_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  owslv_pkg::edge_t    edge_in,
    input  owslv_pkg::cfg_t     cfg,
    output owslv_pkg::result_t  result
);

    logic       armed_reg,     armed_next;
    logic [7:0] active_reg,    active_next;
    logic [7:0] shift_reg,     shift_next;
    logic [2:0] bit_idx_reg,   bit_idx_next;
    logic [3:0] byte_idx_reg,  byte_idx_next;
    logic [1:0] phase_reg,     phase_next;
    logic [7:0] last_cmd_reg,  last_cmd_next;

    logic       rom_bit;
    logic       adv_rom;
    logic [7:0] cmd_byte;
    logic [3:0] byte_inc;

    assign rom_bit  = cfg.rom_id[{byte_idx_reg[2:0], bit_idx_reg}];
    assign byte_inc = byte_idx_reg + 4'd1;

    always_comb begin
        armed_next    = armed_reg;
        active_next   = active_reg;
        shift_next    = shift_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        phase_next    = phase_reg;
        last_cmd_next = last_cmd_reg;
        adv_rom       = 1'b0;
        cmd_byte      = shift_reg;
        result        = '0;

        if (edge_in.line_rising) begin
            if (edge_in.low_time_us >= cfg.reset_min_us) begin
                armed_next    = 1'b1;
                active_next   = owslv_pkg::CMD_NONE;
                shift_next    = '0;
                bit_idx_next  = '0;
                byte_idx_next = '0;
                phase_next    = '0;
                result.action   = owslv_pkg::ACT_PRESENCE;
                result.pulse_us = cfg.presence_us;
            end else if (armed_reg && active_reg == owslv_pkg::CMD_NONE) begin
                if (edge_in.low_time_us <= {8'd0, cfg.write_one_max_us}) begin
                    cmd_byte[bit_idx_reg] = 1'b1;
                end
                shift_next = cmd_byte;
                if (bit_idx_reg != 3'd7) begin
                    bit_idx_next = bit_idx_reg + 3'd1;
                end else begin
                    // Byte complete: the command becomes active and the
                    // bit counters start over.
                    result.command_done = 1'b1;
                    last_cmd_next = cmd_byte;
                    active_next   = cmd_byte;
                    shift_next    = '0;
                    bit_idx_next  = '0;
                    byte_idx_next = '0;
                    phase_next    = '0;
                end
            end
        end else if (armed_reg && active_reg == owslv_pkg::CMD_READ_ROM) begin
            if (!rom_bit) begin
                result.action   = owslv_pkg::ACT_HOLD;
                result.pulse_us = cfg.hold_us;
            end
            adv_rom = 1'b1;
        end else if (armed_reg && active_reg == owslv_pkg::CMD_SEARCH_ROM) begin
            if ((phase_reg == 2'd0 && !rom_bit) || (phase_reg == 2'd1 && rom_bit)) begin
                result.action   = owslv_pkg::ACT_HOLD;
                result.pulse_us = cfg.hold_us;
            end
            if (phase_reg == 2'd0 || phase_reg == 2'd1) begin
                phase_next = phase_reg + 2'd1;
            end else begin
                phase_next = '0;
                adv_rom    = 1'b1;
            end
        end

        if (adv_rom) begin
            if (bit_idx_reg != 3'd7) begin
                bit_idx_next = bit_idx_reg + 3'd1;
            end else begin
                bit_idx_next  = '0;
                byte_idx_next = byte_inc;
                if (byte_inc >= owslv_pkg::ROM_BYTES) begin
                    // All 64 ID bits sent: back to taking a command.
                    active_next   = owslv_pkg::CMD_NONE;
                    shift_next    = '0;
                    byte_idx_next = '0;
                    phase_next    = '0;
                end
            end
        end

        if (!armed_next) begin
            result.mode = owslv_pkg::MODE_OTHER;
        end else if (active_next == owslv_pkg::CMD_NONE) begin
            result.mode = owslv_pkg::MODE_COMMAND;
        end else if (active_next == owslv_pkg::CMD_READ_ROM) begin
            result.mode = owslv_pkg::MODE_READ;
        end else if (active_next == owslv_pkg::CMD_SEARCH_ROM) begin
            result.mode = owslv_pkg::MODE_SEARCH;
        end else begin
            result.mode = owslv_pkg::MODE_OTHER;
        end
        result.command_byte = last_cmd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg    <= 1'b0;
            active_reg   <= '0;
            shift_reg    <= '0;
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
            phase_reg    <= '0;
            last_cmd_reg <= '0;
        end else if (step) begin
            armed_reg    <= armed_next;
            active_reg   <= active_next;
            shift_reg    <= shift_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            phase_reg    <= phase_next;
            last_cmd_reg <= last_cmd_next;
        end
    end

endmodule

// File: hdl/onewire_slave_rom_responder_core.sv
// ----------------------------------------------------------------------------
// onewire_slave_rom_responder_core
// 1-Wire slave answering READ ROM and SEARCH ROM, one bus edge per word.
// An accepted input word is held in the input register, and its result
// is then written to the result register.
// Throughput: one word per cycle while the result word is not stalled,
// set by the single state update between the two registers.
// Reset: synchronous, active low; clears protocol state, both valid flags
// and loads the configuration defaults.
// ----------------------------------------------------------------------------
module onewire_slave_rom_responder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [owslv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owslv_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [owslv_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] low_time_us
    input  logic                                s_tuser,   // [0] line_rising
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] action, [9:2] pulse_us, [11:10] mode, [12] command_done,
    // [20:13] command_byte, [23:21] zero
    output logic [owslv_pkg::OUT_DATA_W-1:0]    m_tdata
);

    owslv_pkg::cfg_t    cfg;
    owslv_pkg::edge_t   in_reg;
    owslv_pkg::result_t result;
    owslv_pkg::result_t out_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    owslv_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held word moves into the result register whenever that register
    // is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    owslv_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .edge_in (in_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.line_rising <= s_tuser;
            in_reg.low_time_us <= s_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.command_byte, out_reg.command_done,
                       out_reg.mode, out_reg.pulse_us, out_reg.action};

endmodule

// File: hdl/owslv_checker.sv
// ----------------------------------------------------------------------------
// owslv_checker
// Port-level checks on the result stream of the ROM responder.
// ----------------------------------------------------------------------------
module owslv_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [owslv_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // A stalled result word must stay put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pulse_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == owslv_pkg::ACT_NONE |-> m_tdata[9:2] == 8'd0)
        else $error("pulse length without an action");

    // A presence request always leaves the slave waiting for a command.
    a_presence_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == owslv_pkg::ACT_PRESENCE
        |-> m_tdata[11:10] == owslv_pkg::MODE_COMMAND && !m_tdata[12])
        else $error("presence request outside command mode");

    a_done_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[1:0] == owslv_pkg::ACT_NONE)
        else $error("action on a command-complete word");

endmodule

bind onewire_slave_rom_responder_core owslv_checker u_owslv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
